// ===== rtl/bucketed_max_mean_aggregator_unit_defines.svh =====
// assertion macros used by the checker file
`ifndef BUCKETED_MAX_MEAN_AGGREGATOR_UNIT_DEFINES_SVH
`define BUCKETED_MAX_MEAN_AGGREGATOR_UNIT_DEFINES_SVH

// same-cycle implication, off while reset is held
`define BMMA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define BMMA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also runs through reset
`define BMMA_ASSERT_RST(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bmma_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bmma_pkg;

    localparam int BUCKETS_DEFAULT = 1024;

    localparam int OP_W     = 2;
    localparam int BUCKET_W = 10;
    localparam int VALUE_W  = 64;
    localparam int COUNT_W  = 32;

    localparam int IN_DATA_W  = 80;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 176;
    localparam int OUT_USER_W = 1;

    localparam logic [OP_W-1:0] OP_ACC   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam int QUEUE_DEPTH = 4;
    localparam int DIV_STEPS   = VALUE_W;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [BUCKET_W-1:0] bucket;
        logic                in_range;
        logic [VALUE_W-1:0]  value;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

// ===== rtl/bmma_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bmma_front #(
    parameter int BUCKETS = bmma_pkg::BUCKETS_DEFAULT
) (
    input  wire logic                           i_tvalid,
    output logic                                o_tready,
    input  wire logic [bmma_pkg::IN_DATA_W-1:0] i_tdata,
    input  wire logic [bmma_pkg::IN_USER_W-1:0] i_tuser,
    input  wire bmma_pkg::t_q_stat              i_q_stat,
    input  wire logic                           i_clearing,
    output logic                                o_push,
    output bmma_pkg::t_cmd                      o_cmd
);

    logic [bmma_pkg::OP_W-1:0]     op;
    logic [bmma_pkg::BUCKET_W-1:0] bucket;
    logic                          present;
    logic                          in_range;
    logic                          keep;

    assign op       = i_tuser[bmma_pkg::OP_W-1:0];
    assign present  = i_tuser[bmma_pkg::OP_W];
    assign bucket   = i_tdata[bmma_pkg::BUCKET_W-1:0];
    assign in_range = 32'(bucket) < 32'(BUCKETS);

    // only items that touch the store or give a result go into the queue
    always_comb begin
        case (op)
            bmma_pkg::OP_ACC:   keep = present && in_range;
            bmma_pkg::OP_READ:  keep = 1'b1;
            bmma_pkg::OP_CLEAR: keep = in_range;
            default:            keep = 1'b0;
        endcase
    end

    assign o_tready = !i_q_stat.full && !i_clearing;
    assign o_push   = i_tvalid && o_tready && keep;

    assign o_cmd.op       = op;
    assign o_cmd.bucket   = bucket;
    assign o_cmd.in_range = in_range;
    assign o_cmd.value    = i_tdata[bmma_pkg::BUCKET_W +: bmma_pkg::VALUE_W];

endmodule

`default_nettype wire

// ===== rtl/bmma_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bmma_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire bmma_pkg::t_cmd i_cmd,
    input  wire logic           i_pop,
    output bmma_pkg::t_cmd      o_cmd,
    output bmma_pkg::t_q_stat   o_stat
);

    localparam int DEPTH = bmma_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    bmma_pkg::t_cmd r_slots [DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;
    logic           do_push;
    logic           do_pop;

    assign do_push = i_push && (r_count != CW'(DEPTH));
    assign do_pop  = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_cmd        = r_slots[r_rd_ptr];
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

`default_nettype wire

// ===== rtl/bmma_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bmma_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [bmma_pkg::VALUE_W-1:0] i_sum,
    input  wire logic [bmma_pkg::COUNT_W-1:0] i_count,
    output bmma_pkg::t_div_stat               o_stat,
    output logic [bmma_pkg::VALUE_W-1:0]      o_quot
);

    localparam int VW = bmma_pkg::VALUE_W;
    localparam int DW = bmma_pkg::COUNT_W;
    localparam int SW = $clog2(bmma_pkg::DIV_STEPS);

    logic          r_busy;
    logic          r_done;
    logic [SW-1:0] r_cnt;
    logic          r_neg;
    logic [VW-1:0] r_q;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_d;

    logic [DW:0]   rem_sh;
    logic          ge;
    logic [DW:0]   rem_nx;

    // restoring division, one quotient bit per cycle, dividend shifts out of r_q
    assign rem_sh = {r_rem[DW-1:0], r_q[VW-1]};
    assign ge     = rem_sh >= {1'b0, r_d};
    assign rem_nx = ge ? rem_sh - {1'b0, r_d} : rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == SW'(bmma_pkg::DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_sum[VW-1];
            r_q   <= i_sum[VW-1] ? (VW'(0) - i_sum) : i_sum;
            r_rem <= '0;
            r_d   <= i_count;
        end else if (r_busy) begin
            r_rem <= rem_nx;
            r_q   <= {r_q[VW-2:0], ge};
        end
    end

    // truncation toward zero: divide the magnitude, then put the sign back
    assign o_quot      = r_neg ? (VW'(0) - r_q) : r_q;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

// ===== rtl/bmma_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bmma_back #(
    parameter int BUCKETS = bmma_pkg::BUCKETS_DEFAULT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire bmma_pkg::t_q_stat               i_q_stat,
    input  wire bmma_pkg::t_cmd                  i_cmd,
    output logic                                 o_pop,
    output logic                                 o_clearing,
    output logic                                 o_div_start,
    output logic [bmma_pkg::VALUE_W-1:0]         o_div_sum,
    output logic [bmma_pkg::COUNT_W-1:0]         o_div_count,
    input  wire bmma_pkg::t_div_stat             i_div_stat,
    input  wire logic [bmma_pkg::VALUE_W-1:0]    i_div_quot,
    output logic                                 o_tvalid,
    input  wire logic                            i_tready,
    output logic [bmma_pkg::OUT_DATA_W-1:0]      o_tdata,
    output logic [bmma_pkg::OUT_USER_W-1:0]      o_tuser
);

    localparam int AW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int VW      = bmma_pkg::VALUE_W;
    localparam int CNW     = bmma_pkg::COUNT_W;
    localparam int ENTRY_W = 2 * VW + CNW;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    // entry layout: max, sum, count from the top down
    logic [ENTRY_W-1:0] r_mem [BUCKETS];
    logic [ENTRY_W-1:0] r_rd_data;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    bmma_pkg::t_cmd r_cmd, n_cmd;

    logic [bmma_pkg::BUCKET_W-1:0] r_res_bucket, n_res_bucket;
    logic [VW-1:0]  r_res_max, n_res_max;
    logic [VW-1:0]  r_res_mean, n_res_mean;
    logic [CNW-1:0] r_res_count, n_res_count;
    logic           r_res_empty, n_res_empty;

    logic                              r_out_valid;
    logic [bmma_pkg::OUT_DATA_W-1:0]   r_out_data;
    logic [bmma_pkg::OUT_USER_W-1:0]   r_out_user;

    logic               we;
    logic [AW-1:0]      w_addr;
    logic [ENTRY_W-1:0] w_data;
    logic [AW-1:0]      rd_addr;
    logic               out_load;
    logic               out_free;

    logic [VW-1:0]  rd_max;
    logic [VW-1:0]  rd_sum;
    logic [CNW-1:0] rd_count;
    logic           take_new_max;
    logic [VW-1:0]  acc_max;
    logic [VW-1:0]  acc_sum;
    logic [CNW-1:0] acc_count;

    assign rd_max   = r_rd_data[ENTRY_W-1 -: VW];
    assign rd_sum   = r_rd_data[CNW +: VW];
    assign rd_count = r_rd_data[CNW-1:0];

    // first sample of a bucket sets the maximum
    assign take_new_max = (rd_count == '0) || ($signed(r_cmd.value) > $signed(rd_max));
    assign acc_max      = take_new_max ? r_cmd.value : rd_max;
    assign acc_sum      = rd_sum + r_cmd.value;
    assign acc_count    = (rd_count == bmma_pkg::COUNT_MAX) ? rd_count : rd_count + 1'b1;

    assign out_free = !r_out_valid || i_tready;
    assign rd_addr  = AW'(i_cmd.bucket);

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_cmd        = r_cmd;
        n_res_bucket = r_res_bucket;
        n_res_max    = r_res_max;
        n_res_mean   = r_res_mean;
        n_res_count  = r_res_count;
        n_res_empty  = r_res_empty;
        o_pop        = 1'b0;
        we           = 1'b0;
        w_addr       = AW'(r_cmd.bucket);
        w_data       = '0;
        o_div_start  = 1'b0;
        out_load     = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                we     = 1'b1;
                w_addr = r_clr_addr;
                if (r_clr_addr == AW'(BUCKETS - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    if (i_cmd.op == bmma_pkg::OP_CLEAR) begin
                        we     = 1'b1;
                        w_addr = AW'(i_cmd.bucket);
                    end else begin
                        n_state = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                if (r_cmd.op == bmma_pkg::OP_ACC) begin
                    we      = 1'b1;
                    w_data  = {acc_max, acc_sum, acc_count};
                    n_state = ST_IDLE;
                end else begin
                    n_res_bucket = r_cmd.bucket;
                    if (!r_cmd.in_range || rd_count == '0) begin
                        n_res_max   = '0;
                        n_res_mean  = '0;
                        n_res_count = '0;
                        n_res_empty = 1'b1;
                        n_state     = ST_OUT;
                    end else begin
                        n_res_max   = rd_max;
                        n_res_count = rd_count;
                        n_res_empty = 1'b0;
                        o_div_start = 1'b1;
                        n_state     = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (i_div_stat.done) begin
                    n_res_mean = i_div_quot;
                    n_state    = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_res_bucket <= n_res_bucket;
        r_res_max    <= n_res_max;
        r_res_mean   <= n_res_mean;
        r_res_count  <= n_res_count;
        r_res_empty  <= n_res_empty;
        if (out_load) begin
            r_out_data <= bmma_pkg::OUT_DATA_W'({r_res_count, r_res_mean, r_res_max,
                                                 r_res_bucket});
            r_out_user <= r_res_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[w_addr] <= w_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_clearing  = (r_state == ST_CLEAR);
    assign o_div_sum   = rd_sum;
    assign o_div_count = rd_count;
    assign o_tvalid    = r_out_valid;
    assign o_tdata     = r_out_data;
    assign o_tuser     = r_out_user;

endmodule

`default_nettype wire

// ===== rtl/bucketed_max_mean_aggregator_unit.sv =====
// channel   dir   handshake                      tdata                         tuser
// s_axis    in    s_axis_tvalid/s_axis_tready    bucket, sample_value          operation, present
// m_axis    out   m_axis_tvalid/m_axis_tready    out_bucket, max, mean, count  empty_res
//
// after reset a clearing pass zeroes the store, one bucket per cycle;
// s_axis_tready stays low during the pass.
// an accumulate in the back end reads the store, then updates and writes it;
// a clear writes the store as it leaves the queue; a read of an empty bucket reads the
// store, then offers the result; for a filled one the bit-serial divider runs in between.
// a 4-entry queue parts intake from the store, so s_axis keeps taking items while
// m_axis is stalled, until the queue fills.
`timescale 1ns / 1ps
`default_nettype none

module bucketed_max_mean_aggregator_unit #(
    parameter int BUCKETS = bmma_pkg::BUCKETS_DEFAULT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [9:0] bucket, [73:10] sample_value, [79:74] zero
    input  wire logic [bmma_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] operation, [2] present
    input  wire logic [bmma_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [9:0] out_bucket, [73:10] max_value, [137:74] mean_value,
    // [169:138] sample_count, [175:170] zero
    output logic [bmma_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // [0] empty_res
    output logic [bmma_pkg::OUT_USER_W-1:0]      m_axis_tuser
);

    bmma_pkg::t_q_stat   q_stat;
    bmma_pkg::t_cmd      push_cmd;
    bmma_pkg::t_cmd      head_cmd;
    bmma_pkg::t_div_stat div_stat;
    logic                push;
    logic                pop;
    logic                clearing;
    logic                div_start;
    logic [bmma_pkg::VALUE_W-1:0] div_sum;
    logic [bmma_pkg::COUNT_W-1:0] div_count;
    logic [bmma_pkg::VALUE_W-1:0] div_quot;

    bmma_front #(
        .BUCKETS (BUCKETS)
    ) u_front (
        .i_tvalid   (s_axis_tvalid),
        .o_tready   (s_axis_tready),
        .i_tdata    (s_axis_tdata),
        .i_tuser    (s_axis_tuser),
        .i_q_stat   (q_stat),
        .i_clearing (clearing),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    bmma_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (q_stat)
    );

    bmma_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_sum   (div_sum),
        .i_count (div_count),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    bmma_back #(
        .BUCKETS (BUCKETS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_clearing  (clearing),
        .o_div_start (div_start),
        .o_div_sum   (div_sum),
        .o_div_count (div_count),
        .i_div_stat  (div_stat),
        .i_div_quot  (div_quot),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tuser     (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ===== rtl/bmma_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "bucketed_max_mean_aggregator_unit_defines.svh"

module bmma_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic [bmma_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input wire logic [bmma_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [bmma_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic [bmma_pkg::OUT_USER_W-1:0] m_axis_tuser
);

    // nothing is offered on the result side straight out of reset
    `BMMA_ASSERT_RST(a_rst_no_result, i_clk, !i_rst_n, !m_axis_tvalid, "result offered after reset")

    // the clearing pass holds intake off in the first cycle after reset
    `BMMA_ASSERT_IMP(a_clear_blocks_intake, i_clk, i_rst_n, $rose(i_rst_n), !s_axis_tready, "intake open during clearing pass")

    // an empty bucket reports zero max, mean and count, a filled one a non-zero count
    `BMMA_ASSERT_IMP(a_empty_consistent, i_clk, i_rst_n, m_axis_tvalid, (m_axis_tuser[0] == (m_axis_tdata[169:138] == '0)) && (!m_axis_tuser[0] || (m_axis_tdata[169:10] == '0)), "empty flag disagrees with fields")

    `BMMA_ASSERT_NXT(a_out_valid_holds, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")

    `BMMA_ASSERT_NXT(a_out_payload_holds, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

endmodule

bind bucketed_max_mean_aggregator_unit bmma_checker u_bmma_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== verif/bucketed_max_mean_aggregator_unit_test.sv =====
`timescale 1ns / 1ps

module bucketed_max_mean_aggregator_unit_test;

    import bmma_pkg::*;

    localparam int N_BUCKETS = BUCKETS_DEFAULT;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [VALUE_W-1:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] VAL_MIN = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [BUCKET_W-1:0] bucket;
        logic [VALUE_W-1:0]  value;
        logic                present;
    } t_agg_item;

    typedef struct packed {
        logic [BUCKET_W-1:0] bucket;
        logic [VALUE_W-1:0]  max_val;
        logic [VALUE_W-1:0]  mean_val;
        logic [COUNT_W-1:0]  count;
        logic                empty;
    } t_agg_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [IN_USER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    // shadow of the bucket table
    logic [VALUE_W-1:0] max_tab   [N_BUCKETS];
    logic [VALUE_W-1:0] sum_tab   [N_BUCKETS];
    logic [COUNT_W-1:0] count_tab [N_BUCKETS];

    t_agg_result agg_result_q[$];
    int          mismatch_cnt;
    bit          tx_idle_on;
    bit          rx_stall_on;
    logic [BUCKET_W-1:0] hot_buckets[8];

    bucketed_max_mean_aggregator_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int gap_len(input bit enabled);
        int roll;
        roll = $urandom_range(0, 99);
        if (!enabled || roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // sum / count rounded toward zero
    function automatic logic [VALUE_W-1:0] trunc_mean(input logic [VALUE_W-1:0] sum,
                                                      input logic [COUNT_W-1:0] count);
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] quo;
        mag = sum[VALUE_W-1] ? -sum : sum;
        quo = mag / {{(VALUE_W-COUNT_W){1'b0}}, count};
        return sum[VALUE_W-1] ? -quo : quo;
    endfunction

    function automatic void aggregate_item(input t_agg_item it);
        t_agg_result res;
        bit          in_range;
        in_range = int'(it.bucket) < N_BUCKETS;
        case (it.op)
            OP_ACC: begin
                if (in_range && it.present) begin
                    if (count_tab[it.bucket] == '0 ||
                        $signed(it.value) > $signed(max_tab[it.bucket]))
                        max_tab[it.bucket] = it.value;
                    sum_tab[it.bucket] = sum_tab[it.bucket] + it.value;
                    if (count_tab[it.bucket] != COUNT_MAX)
                        count_tab[it.bucket] = count_tab[it.bucket] + 1'b1;
                end
            end
            OP_READ: begin
                res = '0;
                res.bucket = it.bucket;
                if (in_range && count_tab[it.bucket] != '0) begin
                    res.count    = count_tab[it.bucket];
                    res.max_val  = max_tab[it.bucket];
                    res.mean_val = trunc_mean(sum_tab[it.bucket], count_tab[it.bucket]);
                end
                res.empty = (res.count == '0);
                agg_result_q.push_back(res);
            end
            OP_CLEAR: begin
                if (in_range) begin
                    max_tab[it.bucket]   = '0;
                    sum_tab[it.bucket]   = '0;
                    count_tab[it.bucket] = '0;
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        $display("mismatch %s: got %h, want %h at %0t ns", what, got, want, $time);
        mismatch_cnt++;
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input logic [OP_W-1:0] op, input logic [BUCKET_W-1:0] bucket,
                             input logic [VALUE_W-1:0] value, input logic present);
        t_agg_item it;
        int        gap;
        it  = '{op: op, bucket: bucket, value: value, present: present};
        gap = gap_len(tx_idle_on);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W-BUCKET_W-VALUE_W){1'b0}}, value, bucket};
        s_axis_tuser  <= {present, op};
        do @(posedge i_clk); while (!s_axis_tready);
        aggregate_item(it);
        @(negedge i_clk);
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (agg_result_q.size() != 0) @(negedge i_clk);
    endtask

    // sink side with random back-pressure
    initial begin : sink_side
        int hold;
        hold = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                hold--;
            end else begin
                m_axis_tready <= 1'b1;
                if (rx_stall_on && $urandom_range(0, 3) == 0) hold = gap_len(1'b1);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_agg_result want;
        t_agg_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.bucket   = m_axis_tdata[9:0];
            got.max_val  = m_axis_tdata[73:10];
            got.mean_val = m_axis_tdata[137:74];
            got.count    = m_axis_tdata[169:138];
            got.empty    = m_axis_tuser[0];
            if (agg_result_q.size() == 0) begin
                report_mismatch("unexpected result, bucket", 64'(got.bucket), '0);
            end else begin
                want = agg_result_q.pop_front();
                if (got.bucket != want.bucket)
                    report_mismatch("out_bucket", 64'(got.bucket), 64'(want.bucket));
                if (got.max_val != want.max_val)
                    report_mismatch("max_value", got.max_val, want.max_val);
                if (got.mean_val != want.mean_val)
                    report_mismatch("mean_value", got.mean_val, want.mean_val);
                if (got.count != want.count)
                    report_mismatch("sample_count", 64'(got.count), 64'(want.count));
                if (got.empty != want.empty)
                    report_mismatch("empty_res", 64'(got.empty), 64'(want.empty));
            end
        end
    end

    task automatic test_empty_reads();
        send_item(OP_READ, 10'd0, '0, 1'b0);
        send_item(OP_READ, 10'd1023, '1, 1'b1);
    endtask

    task automatic test_extreme_samples();
        send_item(OP_ACC, 10'd0, VAL_MAX, 1'b1);
        send_item(OP_ACC, 10'd0, VAL_MIN, 1'b1);
        send_item(OP_READ, 10'd0, '0, 1'b0);
        // two largest positives make the sum wrap
        send_item(OP_ACC, 10'd5, VAL_MAX, 1'b1);
        send_item(OP_ACC, 10'd5, VAL_MAX, 1'b1);
        send_item(OP_READ, 10'd5, '0, 1'b0);
        send_item(OP_ACC, 10'h2AA, '1, 1'b1);
        send_item(OP_ACC, 10'h155, 64'h5555_5555_5555_5555, 1'b1);
        send_item(OP_READ, 10'h2AA, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        send_item(OP_READ, 10'h155, '0, 1'b0);
    endtask

    // a negative first sample sets the maximum, mean truncates toward zero
    task automatic test_negative_first();
        send_item(OP_ACC, 10'd1023, -64'sd5, 1'b1);
        send_item(OP_ACC, 10'd1023, -64'sd2, 1'b1);
        send_item(OP_READ, 10'd1023, '0, 1'b0);
    endtask

    task automatic test_null_sample();
        send_item(OP_ACC, 10'd1023, 64'd100, 1'b0);
        send_item(OP_READ, 10'd1023, '0, 1'b0);
    endtask

    task automatic test_clear();
        send_item(OP_CLEAR, 10'd0, '1, 1'b1);
        send_item(OP_READ, 10'd0, '0, 1'b0);
        send_item(OP_ACC, 10'd0, -64'sd9, 1'b1);
        send_item(OP_READ, 10'd0, '0, 1'b0);
    endtask

    task automatic test_unused_op();
        send_item(OP_UNUSED, 10'd5, {$urandom, $urandom}, 1'b1);
        send_item(OP_READ, 10'd5, '0, 1'b0);
    endtask

    function automatic logic [VALUE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return {$urandom, $urandom};
            4, 5, 6:    return 64'($signed($urandom_range(0, 2000)) - 1000);
            7:          return VAL_MAX - $urandom_range(0, 3);
            8:          return VAL_MIN + $urandom_range(0, 3);
            default:    return {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0, $urandom};
        endcase
    endfunction

    // mostly hot buckets so reads see filled entries, with noise and rare ops
    task automatic test_random_traffic(input int n_items);
        int                  done;
        int                  roll;
        logic [OP_W-1:0]     op;
        logic [BUCKET_W-1:0] bucket;
        logic                present;
        done = 0;
        while (done < n_items) begin
            if (done % 200 == 0) begin
                tx_idle_on  = $urandom_range(0, 3) != 0;
                rx_stall_on = $urandom_range(0, 3) != 0;
            end
            roll = $urandom_range(0, 99);
            if (roll < 58)      op = OP_ACC;
            else if (roll < 90) op = OP_READ;
            else if (roll < 96) op = OP_CLEAR;
            else                op = OP_UNUSED;
            bucket = ($urandom_range(0, 9) < 8) ? hot_buckets[3'($urandom_range(0, 7))]
                                                : BUCKET_W'($urandom_range(0, N_BUCKETS - 1));
            present = $urandom_range(0, 9) != 0;
            send_item(op, bucket, pick_sample(), present);
            done++;
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        mismatch_cnt  = 0;
        tx_idle_on    = 1'b1;
        rx_stall_on   = 1'b1;
        for (int b = 0; b < N_BUCKETS; b++) begin
            max_tab[b]   = '0;
            sum_tab[b]   = '0;
            count_tab[b] = '0;
        end
        foreach (hot_buckets[h]) hot_buckets[h] = BUCKET_W'($urandom_range(0, N_BUCKETS - 1));
        hot_buckets[0] = '0;
        hot_buckets[1] = '1;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_reads();
        test_extreme_samples();
        test_negative_first();
        test_null_sample();
        test_clear();
        test_unused_op();
        test_random_traffic(940);
        // hold off the sender until every read has come back
        wait_results_drained();
        test_random_traffic(937);

        wait_results_drained();
        repeat (100) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
